// ===== src/ips_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared constants and types for the inverter power-up sequencer.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int unsigned PedalW        = 13;
  localparam int unsigned MaskW         = 3;
  localparam int unsigned TorqueW       = 16;
  localparam int unsigned MaxTorqueW    = 15;
  localparam int unsigned HoldW         = 6;
  localparam int unsigned PhaseW        = 3;
  localparam int unsigned LampW         = 6;
  localparam int unsigned TargetW       = 4;
  localparam int unsigned LatchW        = 12;
  localparam int unsigned BeatW         = 4;
  localparam int unsigned PedalFracBits = 12;
  localparam int unsigned ProdW         = PedalW + MaxTorqueW;
  localparam int unsigned FullW         = PedalFracBits + 1;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [MaxTorqueW-1:0] MaxTorqueRst = MaxTorqueW'(1000);
  localparam logic [HoldW-1:0]      HoldRst      = HoldW'(50);
  localparam logic [HoldW-1:0]      HoldMax      = HoldW'(62);
  localparam logic [BeatW-1:0]      BeatLast     = BeatW'(9);

  localparam logic [MaskW-1:0]   MaskAll     = '1;
  localparam logic [TargetW-1:0] TargetNone  = TargetW'(0);
  localparam logic [TargetW-1:0] TargetFl    = TargetW'(1);
  localparam logic [TargetW-1:0] TargetAll   = TargetW'(15);

  // register index
  localparam logic RegMaxTorque = 1'b0;
  localparam logic RegHoldTicks = 1'b1;

  // phase codes
  localparam logic [PhaseW-1:0] PhNotReady  = 3'd0;
  localparam logic [PhaseW-1:0] PhPowered   = 3'd1;
  localparam logic [PhaseW-1:0] PhPrecharge = 3'd2;
  localparam logic [PhaseW-1:0] PhWait      = 3'd3;
  localparam logic [PhaseW-1:0] PhStandby   = 3'd4;
  localparam logic [PhaseW-1:0] PhRun       = 3'd5;
  localparam logic [PhaseW-1:0] PhShutdown  = 3'd6;

  // latch bit positions
  localparam int unsigned LPrecharge = 0;
  localparam int unsigned LInterlock = 1;
  localparam int unsigned LActivate  = 2;
  localparam int unsigned LDcOn      = 3;
  localparam int unsigned LEnable    = 4;
  localparam int unsigned LInvOn     = 5;
  localparam int unsigned LLampMain  = 6;
  localparam int unsigned LLampDrv   = 7;
  localparam int unsigned LLampSns   = 8;
  localparam int unsigned LLampFl    = 9;
  localparam int unsigned LLampFr    = 10;
  localparam int unsigned LLampRl    = 11;

  typedef struct packed {
    logic [PhaseW-1:0]        phase;
    logic [LatchW-1:0]        latches;
    logic                     heartbeat;
    logic signed [TorqueW-1:0] torque_value;
    logic [MaxTorqueW-1:0]    torque_limit;
    logic [TargetW-1:0]       torque_targets;
  } result_t;

endpackage

// ===== src/ips_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_in_if / ips_out_if
// Valid/ready channels for status ticks and sequencer results.
// ----------------------------------------------------------------------------
interface ips_in_if;
  logic        valid;
  logic        ready;
  logic        main_switch;
  logic        ready_button;
  logic [12:0] pedal_position;
  logic [2:0]  ready_mask;
  logic [2:0]  precharged_mask;
  logic [2:0]  dc_echo_mask;
  logic [2:0]  dc_quit_mask;
  logic [2:0]  inv_echo_mask;
  logic [2:0]  inv_quit_mask;

  modport source (
    output valid, main_switch, ready_button, pedal_position, ready_mask,
           precharged_mask, dc_echo_mask, dc_quit_mask, inv_echo_mask, inv_quit_mask,
    input  ready
  );
  modport sink (
    input  valid, main_switch, ready_button, pedal_position, ready_mask,
           precharged_mask, dc_echo_mask, dc_quit_mask, inv_echo_mask, inv_quit_mask,
    output ready
  );
endinterface

interface ips_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               precharge_relay;
  logic               interlock_relay;
  logic               activate_relay;
  logic               dc_on_command;
  logic               enable_command;
  logic               inverter_on_command;
  logic [5:0]         lamp_bits;
  logic               heartbeat;
  logic signed [15:0] torque_value;
  logic [14:0]        torque_limit;
  logic [3:0]         torque_targets;

  modport source (
    output valid, phase, precharge_relay, interlock_relay, activate_relay,
           dc_on_command, enable_command, inverter_on_command, lamp_bits,
           heartbeat, torque_value, torque_limit, torque_targets,
    input  ready
  );
  modport sink (
    input  valid, phase, precharge_relay, interlock_relay, activate_relay,
           dc_on_command, enable_command, inverter_on_command, lamp_bits,
           heartbeat, torque_value, torque_limit, torque_targets,
    output ready
  );
endinterface

// ===== src/inverter_powerup_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverter_powerup_sequencer
// Seven-phase power-up and drive sequencer, one status tick per transaction.
//
//   channel   dir   handshake        content
//   in_i      in    valid/ready      switch, button, pedal, inverter status
//   out_o     out   valid/ready      phase, relays, commands, lamps, torque
//   apb       in    psel/penable     torque scale (0x0), button_hold_ticks (0x4)
//
// One tick per cycle while results are taken; a result appears the cycle after its tick is taken.
// All state updates and the pedal-by-torque product are worked out combinationally.
// The output register holds a result until taken; a new tick is taken
// in the same cycle the held result leaves.
// Reset: phase not ready, latches clear, forward direction, registers default.
// ----------------------------------------------------------------------------
module inverter_powerup_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ips_in_if.sink                           in_i,
  ips_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ips_pkg::ApbAddrW-1:0]     paddr,
  input  logic [ips_pkg::ApbDataW-1:0]     pwdata,
  output logic [ips_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready
);
  import ips_pkg::*;

  logic [MaxTorqueW-1:0] trq_scale_q;
  logic [HoldW-1:0]      hold_ticks_q;
  logic [PhaseW-1:0]     phase_q, phase_d;
  logic [HoldW-1:0]      hold_cnt_q, hold_cnt_d;
  logic                  fwd_q, fwd_d;
  logic [BeatW-1:0]      beat_div_q, beat_div_d;
  logic                  beat_q, beat_d;
  logic [LatchW-1:0]     latch_q, latch_d;
  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [HoldW-1:0]      hold_lim;
  logic [FullW-1:0]      pedal_full;
  logic [PedalW-1:0]     pedal_sat;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      prod_sh;
  logic [TorqueW-1:0]    mag;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trq_scale_q  <= MaxTorqueRst;
      hold_ticks_q <= HoldRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegMaxTorque: trq_scale_q  <= pwdata[MaxTorqueW-1:0];
        RegHoldTicks: hold_ticks_q <= pwdata[HoldW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMaxTorque: prdata = ApbDataW'(trq_scale_q);
      RegHoldTicks: prdata = ApbDataW'(hold_ticks_q);
      default:      prdata = '0;
    endcase
  end

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // torque magnitude
  assign hold_lim   = (hold_ticks_q > HoldMax) ? HoldMax : hold_ticks_q;
  assign pedal_full = FullW'(1) << PedalFracBits;
  assign pedal_sat  = (FullW'(in_i.pedal_position) > pedal_full)
                      ? PedalW'(pedal_full) : in_i.pedal_position;
  assign prod       = ProdW'(pedal_sat) * ProdW'(trq_scale_q);
  assign prod_sh    = prod >> PedalFracBits;
  assign mag        = prod_sh[TorqueW-1:0];

  always_comb begin
    phase_d    = phase_q;
    hold_cnt_d = hold_cnt_q;
    fwd_d      = fwd_q;
    latch_d    = latch_q;
    beat_d     = (beat_div_q == '0) ? ~beat_q : beat_q;
    beat_div_d = (beat_div_q >= BeatLast) ? '0 : beat_div_q + BeatW'(1);

    res_d.torque_value   = '0;
    res_d.torque_limit   = '0;
    res_d.torque_targets = TargetNone;

    unique case (phase_q)
      PhNotReady: begin
        if (in_i.main_switch) phase_d = PhPowered;
      end
      PhPowered: begin
        latch_d[LLampMain] = 1'b1;
        latch_d[LLampFl]   = in_i.ready_mask[0];
        latch_d[LLampFr]   = in_i.ready_mask[1];
        latch_d[LLampRl]   = in_i.ready_mask[2];
        if (in_i.ready_mask == MaskAll) phase_d = PhPrecharge;
      end
      PhPrecharge: begin
        latch_d[LLampDrv]   = 1'b1;
        latch_d[LPrecharge] = 1'b1;
        if (in_i.precharged_mask == MaskAll) begin
          latch_d[LDcOn] = 1'b1;
          if (in_i.dc_echo_mask == MaskAll && in_i.dc_quit_mask == MaskAll) begin
            latch_d[LInterlock] = 1'b1;
            latch_d[LPrecharge] = 1'b0;
            phase_d             = PhWait;
          end
        end
      end
      PhWait: begin
        latch_d[LLampSns]    = 1'b1;
        res_d.torque_targets = TargetAll;
        if (in_i.ready_button) phase_d = PhStandby;
      end
      PhStandby: begin
        latch_d[LLampMain] = 1'b0;
        latch_d[LEnable]   = 1'b1;
        latch_d[LInvOn]    = 1'b1;
        if (in_i.inv_echo_mask[0] && in_i.inv_quit_mask[0]) begin
          latch_d[LActivate] = 1'b1;
          phase_d            = PhRun;
        end
      end
      PhRun: begin
        latch_d[LLampDrv] = 1'b0;
        if (!in_i.ready_button) begin
          hold_cnt_d = '0;
        end else if (hold_cnt_q >= hold_lim) begin
          if (hold_cnt_q == hold_lim) fwd_d = ~fwd_q;
          hold_cnt_d = hold_lim + HoldW'(1);
        end else begin
          hold_cnt_d = hold_cnt_q + HoldW'(1);
        end
        res_d.torque_value   = fwd_d ? $signed(mag) : $signed(-mag);
        res_d.torque_limit   = trq_scale_q;
        res_d.torque_targets = TargetFl;
        if (!in_i.main_switch) phase_d = PhShutdown;
      end
      PhShutdown: begin
        latch_d[LLampSns]    = 1'b0;
        latch_d[LActivate]   = 1'b0;
        latch_d[LInvOn]      = 1'b0;
        res_d.torque_targets = TargetAll;
        if (in_i.inv_echo_mask == '0) begin
          latch_d[LEnable] = 1'b0;
          if (in_i.inv_quit_mask == '0) begin
            latch_d[LDcOn] = 1'b0;
            if (in_i.dc_echo_mask == '0 && in_i.dc_quit_mask == '0) begin
              latch_d[LInterlock] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    res_d.phase     = phase_d;
    res_d.latches   = latch_d;
    res_d.heartbeat = beat_d;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhNotReady;
      hold_cnt_q <= '0;
      fwd_q      <= 1'b1;
      beat_div_q <= '0;
      beat_q     <= 1'b0;
      latch_q    <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      hold_cnt_q <= hold_cnt_d;
      fwd_q      <= fwd_d;
      beat_div_q <= beat_div_d;
      beat_q     <= beat_d;
      latch_q    <= latch_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.phase               = res_q.phase;
  assign out_o.precharge_relay     = res_q.latches[LPrecharge];
  assign out_o.interlock_relay     = res_q.latches[LInterlock];
  assign out_o.activate_relay      = res_q.latches[LActivate];
  assign out_o.dc_on_command       = res_q.latches[LDcOn];
  assign out_o.enable_command      = res_q.latches[LEnable];
  assign out_o.inverter_on_command = res_q.latches[LInvOn];
  assign out_o.lamp_bits           = res_q.latches[LLampRl:LLampMain];
  assign out_o.heartbeat           = res_q.heartbeat;
  assign out_o.torque_value        = res_q.torque_value;
  assign out_o.torque_limit        = res_q.torque_limit;
  assign out_o.torque_targets      = res_q.torque_targets;

endmodule

// ===== src/ips_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks for the inverter power-up sequencer.
// ----------------------------------------------------------------------------
module ips_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ips_pkg::PhaseW-1:0]    phase,
  input logic [ips_pkg::MaxTorqueW-1:0] torque_limit,
  input logic [ips_pkg::TargetW-1:0]   torque_targets
);
  import ips_pkg::*;

  logic shut_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shut_seen_q <= 1'b0;
    end else if (out_valid && out_ready && phase == PhShutdown) begin
      shut_seen_q <= 1'b1;
    end
  end

  // hold a result until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(phase))
    else $error("result dropped or changed while stalled");

  // accept whenever the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // stay in shutdown until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shut_seen_q && out_valid |-> phase == PhShutdown)
    else $error("left shutdown");

  // limit only around run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && torque_limit != '0 |-> phase == PhRun || phase == PhShutdown)
    else $error("torque limit outside run");

  // request targets none, front-left or all
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> torque_targets == TargetNone || torque_targets == TargetFl
                  || torque_targets == TargetAll)
    else $error("bad torque target set");

endmodule

bind inverter_powerup_sequencer ips_checker u_ips_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .phase          (out_o.phase),
  .torque_limit   (out_o.torque_limit),
  .torque_targets (out_o.torque_targets)
);

// ===== verif/ips_tick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_tick_checker
// Watches the tick and result channels and the register port of the
// power-up sequencer. It keeps its own copy of the phase machine, latches,
// debounce counter and heartbeat, and works out the result of each tick that
// is taken. Each result that leaves is compared field by field with the
// oldest one still due. Mismatches and results with no tick behind them are
// counted and reported.
// ----------------------------------------------------------------------------
module ips_tick_checker
  import ips_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ips_in_if                   tick_i,
  ips_out_if                  res_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output int unsigned         fail_count_o,
  output int unsigned         results_due_o
);

  localparam logic [FullW-1:0] PedalFull = FullW'(1) << PedalFracBits;

  logic [PhaseW-1:0]     phase_q;
  logic [HoldW-1:0]      hold_cnt;
  logic                  fwd_dir;
  logic [BeatW-1:0]      beat_div;
  logic                  beat_lvl;
  logic [LatchW-1:0]     latch_q;
  logic [MaxTorqueW-1:0] max_trq;
  logic [HoldW-1:0]      hold_cfg;
  result_t               results_due[$];
  int unsigned           fails = 0;

  task advance_sequencer(output result_t r);
    logic [FullW-1:0]   pedal_sat;
    logic [HoldW-1:0]   hold_lim;
    logic [ProdW-1:0]   product;
    logic [TorqueW-1:0] mag;
    r = '0;
    if (beat_div == '0) beat_lvl = ~beat_lvl;
    beat_div = (beat_div >= BeatLast) ? '0 : beat_div + 1'b1;
    case (phase_q)
      PhNotReady: begin
        if (tick_i.main_switch) phase_q = PhPowered;
      end
      PhPowered: begin
        latch_q[LLampMain] = 1'b1;
        latch_q[LLampFl]   = tick_i.ready_mask[0];
        latch_q[LLampFr]   = tick_i.ready_mask[1];
        latch_q[LLampRl]   = tick_i.ready_mask[2];
        if (tick_i.ready_mask == MaskAll) phase_q = PhPrecharge;
      end
      PhPrecharge: begin
        latch_q[LLampDrv]   = 1'b1;
        latch_q[LPrecharge] = 1'b1;
        if (tick_i.precharged_mask == MaskAll) begin
          latch_q[LDcOn] = 1'b1;
          if (tick_i.dc_echo_mask == MaskAll && tick_i.dc_quit_mask == MaskAll) begin
            latch_q[LInterlock] = 1'b1;
            latch_q[LPrecharge] = 1'b0;
            phase_q = PhWait;
          end
        end
      end
      PhWait: begin
        latch_q[LLampSns] = 1'b1;
        r.torque_targets = TargetAll;
        if (tick_i.ready_button) phase_q = PhStandby;
      end
      PhStandby: begin
        latch_q[LLampMain] = 1'b0;
        latch_q[LEnable]   = 1'b1;
        latch_q[LInvOn]    = 1'b1;
        if (tick_i.inv_echo_mask[0] && tick_i.inv_quit_mask[0]) begin
          latch_q[LActivate] = 1'b1;
          phase_q = PhRun;
        end
      end
      PhRun: begin
        hold_lim  = (hold_cfg > HoldMax) ? HoldMax : hold_cfg;
        pedal_sat = (tick_i.pedal_position > PedalFull) ? PedalFull
                                                        : tick_i.pedal_position;
        latch_q[LLampDrv] = 1'b0;
        if (!tick_i.ready_button) begin
          hold_cnt = '0;
        end else if (hold_cnt >= hold_lim) begin
          if (hold_cnt == hold_lim) fwd_dir = ~fwd_dir;
          hold_cnt = hold_lim + 1'b1;
        end else begin
          hold_cnt = hold_cnt + 1'b1;
        end
        product = ProdW'(pedal_sat) * ProdW'(max_trq);
        mag = product[PedalFracBits +: TorqueW];
        r.torque_value   = fwd_dir ? mag : -mag;
        r.torque_limit   = max_trq;
        r.torque_targets = TargetFl;
        if (!tick_i.main_switch) phase_q = PhShutdown;
      end
      PhShutdown: begin
        latch_q[LLampSns]  = 1'b0;
        latch_q[LActivate] = 1'b0;
        latch_q[LInvOn]    = 1'b0;
        r.torque_targets = TargetAll;
        if (tick_i.inv_echo_mask == '0) begin
          latch_q[LEnable] = 1'b0;
          if (tick_i.inv_quit_mask == '0) begin
            latch_q[LDcOn] = 1'b0;
            if (tick_i.dc_echo_mask == '0 && tick_i.dc_quit_mask == '0) begin
              latch_q[LInterlock] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.phase     = phase_q;
    r.latches   = latch_q;
    r.heartbeat = beat_lvl;
  endtask

  task check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fails++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t next_res;
    if (!rst_ni) begin
      phase_q  = PhNotReady;
      hold_cnt = '0;
      fwd_dir  = 1'b1;
      beat_div = '0;
      beat_lvl = 1'b0;
      latch_q  = '0;
      max_trq  = MaxTorqueRst;
      hold_cfg = HoldRst;
      results_due.delete();
      results_due_o <= 0;
      fail_count_o  <= fails;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ApbAddrW-1])
          RegMaxTorque: max_trq  = pwdata[MaxTorqueW-1:0];
          RegHoldTicks: hold_cfg = pwdata[HoldW-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (results_due.size() == 0) begin
          fails++;
          $display("%0t ns: result transaction with no tick pending", $time);
        end else begin
          want = results_due.pop_front();
          check_field("phase", want.phase, res_i.phase);
          check_field("precharge_relay", want.latches[LPrecharge], res_i.precharge_relay);
          check_field("interlock_relay", want.latches[LInterlock], res_i.interlock_relay);
          check_field("activate_relay", want.latches[LActivate], res_i.activate_relay);
          check_field("dc_on_command", want.latches[LDcOn], res_i.dc_on_command);
          check_field("enable_command", want.latches[LEnable], res_i.enable_command);
          check_field("inverter_on_command", want.latches[LInvOn],
                      res_i.inverter_on_command);
          check_field("lamp_bits", want.latches[LatchW-1:LLampMain], res_i.lamp_bits);
          check_field("heartbeat", want.heartbeat, res_i.heartbeat);
          check_field("torque_value", want.torque_value, res_i.torque_value);
          check_field("torque_limit", want.torque_limit, res_i.torque_limit);
          check_field("torque_targets", want.torque_targets, res_i.torque_targets);
        end
      end
      if (tick_i.valid && tick_i.ready) begin
        advance_sequencer(next_res);
        results_due.push_back(next_res);
      end
      results_due_o <= results_due.size();
      fail_count_o  <= fails;
    end
  end

endmodule

// ===== verif/tb_inverter_powerup_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverter_powerup_sequencer
// Drives the power-up sequencer through every phase once: a directed walk
// from not ready to running, long random runs in the running phase under
// several torque and debounce settings, then the shutdown phase. Both
// channels idle at random in bursts. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_inverter_powerup_sequencer;
  import ips_pkg::*;

  localparam logic [PedalW-1:0] PedalFull = PedalW'(1) << PedalFracBits;

  typedef struct {
    logic             sw;
    logic             btn;
    logic [PedalW-1:0] pedal;
    logic [MaskW-1:0] rdy;
    logic [MaskW-1:0] pre;
    logic [MaskW-1:0] dce;
    logic [MaskW-1:0] dcq;
    logic [MaskW-1:0] ive;
    logic [MaskW-1:0] ivq;
  } tick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         fail_count;
  int unsigned         results_due;
  int unsigned         idle_pct = 15;
  int                  press_left = 0;
  int                  release_left = 0;
  logic [HoldW-1:0]    hold_setting = HoldRst;

  ips_in_if  tick_ch ();
  ips_out_if result_ch ();

  inverter_powerup_sequencer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_ch),
    .out_o   (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ips_tick_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_ch),
    .res_i         (result_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && $urandom_range(1, 100) <= idle_pct) stall = $urandom_range(1, 10);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic tick_t make_tick(logic sw, logic btn, logic [PedalW-1:0] pedal,
                                      logic [MaskW-1:0] rdy, logic [MaskW-1:0] pre,
                                      logic [MaskW-1:0] dce, logic [MaskW-1:0] dcq,
                                      logic [MaskW-1:0] ive, logic [MaskW-1:0] ivq);
    tick_t t;
    t.sw = sw;
    t.btn = btn;
    t.pedal = pedal;
    t.rdy = rdy;
    t.pre = pre;
    t.dce = dce;
    t.dcq = dcq;
    t.ive = ive;
    t.ivq = ivq;
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.sw  = 1'($urandom_range(0, 1));
    t.btn = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: t.pedal = PedalW'($urandom_range(0, 8191));
      1: t.pedal = $urandom_range(0, 1) ? PedalFull : '0;
      default: t.pedal = PedalW'($urandom_range(0, 4096));
    endcase
    t.rdy = MaskW'($urandom_range(0, 7));
    t.pre = MaskW'($urandom_range(0, 7));
    t.dce = MaskW'($urandom_range(0, 7));
    t.dcq = MaskW'($urandom_range(0, 7));
    t.ive = MaskW'($urandom_range(0, 7));
    t.ivq = MaskW'($urandom_range(0, 7));
    return t;
  endfunction

  // press lengths cluster around the debounce count so toggles land on both sides
  function automatic logic next_button();
    int lim;
    lim = (hold_setting > HoldMax) ? int'(HoldMax) : int'(hold_setting);
    if (press_left > 0) begin
      press_left--;
      return 1'b1;
    end
    if (release_left > 0) begin
      release_left--;
      return 1'b0;
    end
    release_left = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) press_left = lim + int'($urandom_range(0, 2));
    else press_left = $urandom_range(1, lim + 4);
    return 1'b0;
  endfunction

  task send_tick(input tick_t t);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 10);
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.main_switch     <= t.sw;
    tick_ch.ready_button    <= t.btn;
    tick_ch.pedal_position  <= t.pedal;
    tick_ch.ready_mask      <= t.rdy;
    tick_ch.precharged_mask <= t.pre;
    tick_ch.dc_echo_mask    <= t.dce;
    tick_ch.dc_quit_mask    <= t.dcq;
    tick_ch.inv_echo_mask   <= t.ive;
    tick_ch.inv_quit_mask   <= t.ivq;
    tick_ch.valid           <= 1'b1;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
  endtask

  task stop_source();
    @(negedge clk_i);
    tick_ch.valid <= 1'b0;
  endtask

  task drain();
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task apb_write(input logic idx, input logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task reconfigure(input logic [MaxTorqueW-1:0] trq, input logic [HoldW-1:0] hold);
    stop_source();
    drain();
    apb_write(RegMaxTorque, ApbDataW'(trq));
    apb_write(RegHoldTicks, ApbDataW'(hold));
    hold_setting = hold;
  endtask

  task run_ticks(input int n);
    tick_t t;
    repeat (n) begin
      t = rand_tick();
      t.sw = 1'b1;
      t.btn = next_button();
      send_tick(t);
    end
  endtask

  initial begin
    tick_t t;
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    tick_ch.valid           = 1'b0;
    tick_ch.main_switch     = 1'b0;
    tick_ch.ready_button    = 1'b0;
    tick_ch.pedal_position  = '0;
    tick_ch.ready_mask      = '0;
    tick_ch.precharged_mask = '0;
    tick_ch.dc_echo_mask    = '0;
    tick_ch.dc_quit_mask    = '0;
    tick_ch.inv_echo_mask   = '0;
    tick_ch.inv_quit_mask   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // walk from not ready up to running with the reset settings
    send_tick(make_tick(1'b0, 1'b1, 13'h1FFF, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd5, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd2, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd6, 3'd7, 3'd7, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd7, 3'd7, 3'd3, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd7, 3'd1, 3'd7, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd7, 3'd7, 3'd7, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h1000, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b1, 13'h0000, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd7, 3'd7, 3'd7, 3'd7, 3'd1, 3'd6));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1));
    send_tick(make_tick(1'b1, 1'b0, 13'h1000, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h1001, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b1, 13'h1FFF, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0001, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));

    run_ticks(60);
    reconfigure(MaxTorqueW'(32767), HoldMax);
    idle_pct = 0;
    run_ticks(120);
    reconfigure('0, '0);
    idle_pct = 40;
    run_ticks(60);
    reconfigure(MaxTorqueW'($urandom_range(1, 32766)), HoldW'(63));
    idle_pct = 15;
    run_ticks(120);
    reconfigure(MaxTorqueW'($urandom_range(0, 32767)), HoldW'(1));
    idle_pct = 30;
    run_ticks(80);
    reconfigure(MaxTorqueW'($urandom_range(0, 32767)), HoldW'($urandom_range(2, 61)));
    idle_pct = 10;
    run_ticks(100);

    // shutdown: release the latches step by step, then stay there
    idle_pct = 0;
    send_tick(make_tick(1'b0, 1'b1, 13'h1000, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7));
    send_tick(make_tick(1'b1, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd7, 3'd7, 3'd1, 3'd7));
    send_tick(make_tick(1'b0, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd7, 3'd7, 3'd0, 3'd2));
    send_tick(make_tick(1'b0, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0));
    send_tick(make_tick(1'b0, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0));
    send_tick(make_tick(1'b0, 1'b0, 13'h0000, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    repeat (60) begin
      t = rand_tick();
      if ($urandom_range(0, 1)) t.dce = '0;
      if ($urandom_range(0, 1)) t.dcq = '0;
      if ($urandom_range(0, 1)) t.ive = '0;
      if ($urandom_range(0, 1)) t.ivq = '0;
      send_tick(t);
    end
    stop_source();
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ips_pkg.sv
src/ips_if.sv
src/inverter_powerup_sequencer.sv
src/ips_checker.sv
verif/ips_tick_checker.sv
verif/tb_inverter_powerup_sequencer.sv
